>>> hdl/s2e_pkg.sv
package s2e_pkg;
  localparam int CordicSteps = 32;
  localparam int AccW = 72;
  localparam logic signed [AccW-1:0] PiQ30 = 72'sd3373259426;
  localparam logic signed [AccW-1:0] HalfPiQ30 = 72'sd1686629713;
  localparam logic signed [AccW-1:0] KinvQ30 = 72'sd652032874;
  localparam logic signed [AccW-1:0] KxQ30 = 72'sd966707283;
  localparam logic signed [AccW-1:0] Sqrt2Q30 = 72'sd1518500250;
  localparam int TLimitRad = 8;

  localparam logic [1:0] RegScale = 2'd0;
  localparam logic [1:0] RegTol = 2'd1;
  localparam logic [1:0] RegMaxIt = 2'd2;

  typedef enum logic [1:0] {
    CMODE_VEC,
    CMODE_ROT
  } cmode_t;

  typedef struct packed {
    logic start;
    cmode_t mode;
  } cordic_ctl_t;

  typedef struct packed {
    logic done;
  } cordic_sts_t;

  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] r;
    begin
      case (i)
        5'd0: r = 32'h3243F6A8;
        5'd1: r = 32'h1DAC6705;
        5'd2: r = 32'h0FADBAFC;
        5'd3: r = 32'h07F56EA6;
        5'd4: r = 32'h03FEAB76;
        5'd5: r = 32'h01FFD55B;
        5'd6: r = 32'h00FFFAAA;
        5'd7: r = 32'h007FFF55;
        5'd8: r = 32'h003FFFEA;
        5'd9: r = 32'h001FFFFD;
        5'd10: r = 32'h000FFFFF;
        5'd11: r = 32'h0007FFFF;
        5'd12: r = 32'h0003FFFF;
        5'd13: r = 32'h0001FFFF;
        5'd14: r = 32'h0000FFFF;
        5'd15: r = 32'h00007FFF;
        5'd16: r = 32'h00003FFF;
        5'd17: r = 32'h00001FFF;
        5'd18: r = 32'h00000FFF;
        5'd19: r = 32'h000007FF;
        5'd20: r = 32'h000003FF;
        5'd21: r = 32'h000001FF;
        5'd22: r = 32'h000000FF;
        5'd23: r = 32'h0000007F;
        5'd24: r = 32'h0000003F;
        5'd25: r = 32'h0000001F;
        5'd26: r = 32'h0000000F;
        5'd27: r = 32'h00000008;
        5'd28: r = 32'h00000004;
        5'd29: r = 32'h00000002;
        5'd30: r = 32'h00000001;
        default: r = 32'h00000000;
      endcase
      return r;
    end
  endfunction
endpackage

>>> hdl/s2e_if.sv
interface s2e_in_if #(parameter int COORD_BITS = 16);
  logic valid;
  logic ready;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic signed [COORD_BITS-1:0] pos_z;
  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface s2e_out_if;
  logic valid;
  logic ready;
  logic [15:0] map_x;
  logic [15:0] map_y;
  logic converged;
  logic [13:0] iterations_used;
  modport source (output valid, map_x, map_y, converged, iterations_used, input ready);
  modport sink (input valid, map_x, map_y, converged, iterations_used, output ready);
endinterface

>>> hdl/s2e_cordic.sv
module s2e_cordic (
  input  logic clk,
  input  logic rst_n,
  input  s2e_pkg::cordic_ctl_t ctl,
  input  logic signed [s2e_pkg::AccW-1:0] x_in,
  input  logic signed [s2e_pkg::AccW-1:0] y_in,
  input  logic signed [s2e_pkg::AccW-1:0] z_in,
  output s2e_pkg::cordic_sts_t sts,
  output logic signed [s2e_pkg::AccW-1:0] x_out,
  output logic signed [s2e_pkg::AccW-1:0] y_out,
  output logic signed [s2e_pkg::AccW-1:0] z_out
);
  import s2e_pkg::*;

  logic signed [AccW-1:0] x_r, y_r, z_r;
  logic [4:0] i_r;
  logic busy_r, done_r;
  cmode_t mode_r;
  logic dir;
  logic signed [AccW-1:0] xs, ys, at;

  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;
  assign at = AccW'(signed'({1'b0, atan_q30(i_r)}));
  assign dir = (mode_r == CMODE_VEC) ? (y_r > 0) : (z_r >= 0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r <= '0;
      mode_r <= CMODE_VEC;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        x_r <= x_in;
        y_r <= y_in;
        z_r <= z_in;
        mode_r <= ctl.mode;
        i_r <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (mode_r == CMODE_VEC) begin
          x_r <= dir ? x_r + ys : x_r - ys;
          y_r <= dir ? y_r - xs : y_r + xs;
          z_r <= dir ? z_r + at : z_r - at;
        end else begin
          x_r <= dir ? x_r - ys : x_r + ys;
          y_r <= dir ? y_r + xs : y_r - xs;
          z_r <= dir ? z_r - at : z_r + at;
        end
        i_r <= i_r + 5'd1;
        if (i_r == 5'(CordicSteps - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts.done = done_r;
  assign x_out = x_r;
  assign y_out = y_r;
  assign z_out = z_r;
endmodule

>>> hdl/s2e_div.sv
module s2e_div (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic signed [s2e_pkg::AccW-1:0] num,
  input  logic signed [s2e_pkg::AccW-1:0] den,
  output logic done,
  output logic signed [s2e_pkg::AccW-1:0] quo
);
  import s2e_pkg::*;

  localparam int QW = 48;
  logic [QW-1:0] n_r, q_r;
  logic [QW:0] r_r;
  logic [QW-1:0] d_r;
  logic neg_r, busy_r, done_r;
  logic [5:0] c_r;
  logic [QW:0] rs;

  assign rs = {r_r[QW-1:0], n_r[QW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      c_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        n_r <= QW'(num < 0 ? -num : num);
        d_r <= QW'(den);
        neg_r <= num < 0;
        r_r <= '0;
        q_r <= '0;
        c_r <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        n_r <= n_r << 1;
        if (rs >= {1'b0, d_r}) begin
          r_r <= rs - {1'b0, d_r};
          q_r <= {q_r[QW-2:0], 1'b1};
        end else begin
          r_r <= rs;
          q_r <= {q_r[QW-2:0], 1'b0};
        end
        c_r <= c_r + 6'd1;
        if (c_r == 6'(QW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo = neg_r ? -AccW'(signed'({1'b0, q_r})) : AccW'(signed'({1'b0, q_r}));
endmodule

>>> hdl/sphere_to_ellipse_projection.sv
// Mollweide-style projection of a 3D direction onto an ellipse, Q0.16 output.
// One word at a time: in_ready is high only while idle. The result waits in its
// own output register, so the next word can be taken while it is held. A short
// input vector is first normalized by left shifts (up to 30). Angles, sines and
// cosines run through one shared 32-step CORDIC unit, each Newton step runs a
// 48-step radix-2 divider, and all products go through one shared multiplier.
// Configuration over APB, always ready.
module sphere_to_ellipse_projection #(
  parameter int FRAC_BITS = 16,
  parameter int COORD_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  s2e_in_if.sink in_ch,
  s2e_out_if.source out_ch,
  input  logic cfg_psel,
  input  logic cfg_penable,
  input  logic cfg_pwrite,
  input  logic [3:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);
  import s2e_pkg::*;

  localparam int SH = 30 - FRAC_BITS;
  localparam logic signed [AccW-1:0] One = AccW'(1) <<< FRAC_BITS;
  localparam logic signed [AccW-1:0] TLim = AccW'(TLimitRad) <<< FRAC_BITS;

  typedef enum logic [4:0] {
    S_IDLE, S_NORM, S_SQ, S_SQRT, S_TH_GO, S_TH_W, S_PH_GO, S_PH_W, S_SC_GO,
    S_SC_W, S_C, S_F, S_DIV_W, S_STEP, S_TEST, S_FIN_GO, S_FIN_W, S_M1, S_M2,
    S_M3, S_M4, S_M5, S_OUT
  } state_t;

  state_t st_r;
  logic [15:0] scale_r, tol_r;
  logic [13:0] maxit_r;
  logic signed [AccW-1:0] px_r, py_r, pz_r, rho_r, theta_r, phi_r, c_r, t_r;
  logic signed [AccW-1:0] s2_r, c2_r, p_r, q_r, acc_r;
  logic [63:0] sq_n_r, sq_res_r, sq_bit_r;
  logic [13:0] cnt_r;
  logic conv_r, xneg_r, angle_neg_r, vec_base_r;
  logic signed [AccW-1:0] base_r;
  logic [1:0] sc_tgt_r;
  logic [15:0] mx_r, my_r;
  logic oconv_r;
  logic [13:0] oiter_r;
  logic ovalid_r;

  cordic_ctl_t cctl;
  cordic_sts_t csts;
  logic signed [AccW-1:0] cx_in, cy_in, cz_in, cx, cy, cz;
  logic dstart, ddone;
  logic signed [AccW-1:0] dnum, dden, dq;

  s2e_cordic u_cordic (.clk, .rst_n, .ctl(cctl), .x_in(cx_in), .y_in(cy_in),
    .z_in(cz_in), .sts(csts), .x_out(cx), .y_out(cy), .z_out(cz));
  s2e_div u_div (.clk, .rst_n, .start(dstart), .num(dnum), .den(dden),
    .done(ddone), .quo(dq));

  function automatic logic signed [AccW-1:0] rshr(input logic signed [AccW-1:0] v,
                                                  input int s);
    return (v + (AccW'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [AccW-1:0] iabs(input logic signed [AccW-1:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [15:0] sat16(input logic signed [AccW-1:0] vi);
    logic signed [AccW-1:0] v;
    begin
      if (FRAC_BITS > 16) v = rshr(vi, FRAC_BITS - 16);
      else v = vi <<< (16 - FRAC_BITS);
      if (v < 0) return 16'd0;
      if (v > 65535) return 16'hFFFF;
      return v[15:0];
    end
  endfunction

  // sin/cos argument reduction into [-pi/2, pi/2]
  logic signed [AccW-1:0] ang_src, a_red;
  logic a_neg;
  always_comb begin
    case (sc_tgt_r)
      2'd0: ang_src = phi_r;
      2'd1: ang_src = t_r <<< 1;
      default: ang_src = t_r;
    endcase
    a_red = ang_src <<< SH;
    a_neg = 1'b0;
    // |t| <= 8 so 2t <= 16 rad: at most three turns removed
    for (int k = 0; k < 3; k++) begin
      if (a_red > PiQ30) a_red = a_red - (PiQ30 <<< 1);
      else if (a_red < -PiQ30) a_red = a_red + (PiQ30 <<< 1);
    end
    if (a_red > HalfPiQ30) begin
      a_red = PiQ30 - a_red;
      a_neg = 1'b1;
    end else if (a_red < -HalfPiQ30) begin
      a_red = -PiQ30 - a_red;
      a_neg = 1'b1;
    end
  end

  // vectoring operand prep: (x,y) is (pz,rho) for theta, (px,py) for phi
  logic signed [AccW-1:0] vx, vy, vxn, vyn, vm;
  logic [4:0] vsh;
  always_comb begin
    vx = vec_base_r ? px_r : pz_r;
    vy = vec_base_r ? py_r : rho_r;
    vm = iabs(vx) > iabs(vy) ? iabs(vx) : iabs(vy);
    // shift that brings the larger magnitude up to bit 31
    vsh = '0;
    for (int k = 0; k < 31; k++) begin
      if (vm[k]) vsh = 5'(31 - k);
    end
    if (vm[AccW-1:31] != '0) vsh = '0;
    vxn = vx <<< vsh;
    vyn = vy <<< vsh;
  end

  logic signed [AccW-1:0] fq_y, fq_x;
  assign fq_y = rshr(cy, SH);
  assign fq_x = rshr(angle_neg_r ? -cx : cx, SH);

  always_comb begin
    cctl.start = 1'b0;
    cctl.mode = CMODE_VEC;
    cx_in = vxn[AccW-1] ? -vxn : vxn;
    cy_in = vxn[AccW-1] ? -vyn : vyn;
    cz_in = '0;
    if (st_r == S_TH_GO || st_r == S_PH_GO) cctl.start = 1'b1;
    if (st_r == S_SC_GO || st_r == S_FIN_GO) begin
      cctl.start = 1'b1;
      cctl.mode = CMODE_ROT;
      cx_in = KinvQ30;
      cy_in = '0;
      cz_in = a_red;
    end
  end

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st_r)
      S_NORM: begin
        mul_a = 33'(px_r);
        mul_b = 33'(px_r);
      end
      S_SQ: begin
        mul_a = 33'(py_r);
        mul_b = 33'(py_r);
      end
      S_SC_W: begin
        mul_a = 33'(PiQ30);
        mul_b = 33'(fq_y);
      end
      S_FIN_W: begin
        mul_a = 33'(theta_r);
        mul_b = 33'(fq_x);
      end
      S_M1: begin
        mul_a = 33'(s2_r);
        mul_b = 33'(Sqrt2Q30);
      end
      S_M2: begin
        mul_a = 33'(p_r);
        mul_b = 33'(KxQ30);
      end
      S_M3: begin
        mul_a = 33'(q_r);
        mul_b = 33'(scale_r);
      end
      S_M4: begin
        mul_a = 33'(p_r);
        mul_b = 33'(scale_r);
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  logic signed [AccW-1:0] dcur, fcur;
  assign dcur = (One <<< 1) + (c2_r <<< 1);
  assign fcur = (t_r <<< 1) + s2_r - c_r;
  assign dstart = (st_r == S_F) && (dcur > 0);
  assign dnum = fcur <<< FRAC_BITS;
  assign dden = dcur;

  logic signed [AccW-1:0] tnew, resid;
  logic [63:0] sq_try;
  always_comb begin
    tnew = t_r - dq;
    if (tnew > TLim) tnew = TLim;
    if (tnew < -TLim) tnew = -TLim;
    resid = iabs(fcur);
    sq_try = sq_res_r + sq_bit_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ovalid_r <= 1'b0;
      scale_r <= 16'd10486;
      tol_r <= 16'd655;
      maxit_r <= 14'd10000;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        unique case (cfg_paddr[3:2])
          RegScale: scale_r <= cfg_pwdata[15:0];
          RegTol: tol_r <= cfg_pwdata[15:0];
          RegMaxIt: maxit_r <= cfg_pwdata[13:0];
          default: ;
        endcase
      end
      if (ovalid_r && out_ch.ready) ovalid_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (in_ch.valid) begin
          px_r <= AccW'(in_ch.pos_x);
          py_r <= AccW'(in_ch.pos_y);
          pz_r <= AccW'(in_ch.pos_z);
          xneg_r <= in_ch.pos_x[COORD_BITS-1];
          st_r <= S_NORM;
        end
        S_NORM: begin
          if ((iabs(px_r) | iabs(py_r) | iabs(pz_r)) == 0 ||
              (iabs(px_r) | iabs(py_r) | iabs(pz_r)) >= (AccW'(1) <<< 30)) begin
            acc_r <= AccW'(mul_p);
            st_r <= S_SQ;
          end else begin
            px_r <= px_r <<< 1;
            py_r <= py_r <<< 1;
            pz_r <= pz_r <<< 1;
          end
        end
        S_SQ: begin
          sq_n_r <= 64'(acc_r + AccW'(mul_p));
          sq_res_r <= '0;
          sq_bit_r <= 64'd1 << 62;
          st_r <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_bit_r == 0) begin
            rho_r <= AccW'(signed'({1'b0, sq_res_r}));
            vec_base_r <= 1'b0;
            st_r <= S_TH_GO;
          end else begin
            if (sq_n_r >= sq_try) begin
              sq_n_r <= sq_n_r - sq_try;
              sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
            end else sq_res_r <= sq_res_r >> 1;
            sq_bit_r <= sq_bit_r >> 2;
          end
        end
        S_TH_GO, S_PH_GO: begin
          base_r <= (vm == 0 || !vxn[AccW-1]) ? '0 : (vyn >= 0 ? PiQ30 : -PiQ30);
          if (vm == 0) begin
            if (st_r == S_TH_GO) begin
              theta_r <= '0;
              vec_base_r <= 1'b1;
              st_r <= S_PH_GO;
            end else begin
              phi_r <= '0;
              sc_tgt_r <= 2'd0;
              st_r <= S_SC_GO;
            end
          end else st_r <= (st_r == S_TH_GO) ? S_TH_W : S_PH_W;
        end
        S_TH_W: if (csts.done) begin
          theta_r <= rshr(base_r + cz, SH);
          vec_base_r <= 1'b1;
          st_r <= S_PH_GO;
        end
        S_PH_W: if (csts.done) begin
          phi_r <= rshr(base_r + cz, SH);
          sc_tgt_r <= 2'd0;
          st_r <= S_SC_GO;
        end
        S_SC_GO, S_FIN_GO: begin
          angle_neg_r <= a_neg;
          st_r <= (st_r == S_SC_GO) ? S_SC_W : S_FIN_W;
        end
        S_SC_W: if (csts.done) begin
          if (sc_tgt_r == 2'd0) begin
            acc_r <= AccW'(mul_p);
            st_r <= S_C;
          end else begin
            s2_r <= fq_y;
            c2_r <= fq_x;
            st_r <= (cnt_r == '0) ? S_F : S_TEST;
          end
        end
        S_C: begin
          c_r <= rshr(acc_r, 30);
          t_r <= phi_r;
          cnt_r <= '0;
          conv_r <= 1'b0;
          sc_tgt_r <= 2'd1;
          st_r <= S_SC_GO;
        end
        S_TEST: begin
          if (resid <= AccW'(tol_r)) begin
            conv_r <= 1'b1;
            sc_tgt_r <= 2'd2;
            st_r <= S_FIN_GO;
          end else if (cnt_r >= maxit_r) begin
            sc_tgt_r <= 2'd2;
            st_r <= S_FIN_GO;
          end else begin
            st_r <= S_F;
          end
        end
        S_F: begin
          if (dcur <= 0) begin
            sc_tgt_r <= 2'd2;
            st_r <= S_FIN_GO;
          end else st_r <= S_DIV_W;
        end
        S_DIV_W: if (ddone) st_r <= S_STEP;
        S_STEP: begin
          t_r <= tnew;
          cnt_r <= cnt_r + 14'd1;
          sc_tgt_r <= 2'd1;
          st_r <= S_SC_GO;
        end
        S_FIN_W: if (csts.done) begin
          s2_r <= fq_y;
          acc_r <= AccW'(mul_p);
          st_r <= S_M1;
        end
        S_M1: begin
          p_r <= rshr(acc_r, FRAC_BITS);
          acc_r <= AccW'(mul_p);
          st_r <= S_M2;
        end
        S_M2: begin
          q_r <= rshr(acc_r, 30);
          acc_r <= AccW'(mul_p);
          st_r <= S_M3;
        end
        S_M3: begin
          p_r <= rshr(acc_r, 30);
          acc_r <= AccW'(mul_p);
          st_r <= S_M4;
        end
        S_M4: begin
          q_r <= rshr(acc_r, 16);
          acc_r <= AccW'(mul_p);
          st_r <= S_M5;
        end
        S_M5: begin
          p_r <= rshr(acc_r, 16);
          st_r <= S_OUT;
        end
        S_OUT: if (!ovalid_r) begin
          mx_r <= sat16(xneg_r ? (One >>> 1) + p_r : (One >>> 1) - p_r);
          my_r <= sat16((One >>> 1) + q_r);
          oconv_r <= conv_r;
          oiter_r <= cnt_r;
          ovalid_r <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready = (st_r == S_IDLE);
  assign out_ch.valid = ovalid_r;
  assign out_ch.map_x = mx_r;
  assign out_ch.map_y = my_r;
  assign out_ch.converged = oconv_r;
  assign out_ch.iterations_used = oiter_r;
  assign cfg_pready = 1'b1;
  always_comb begin
    case (cfg_paddr[3:2])
      RegScale: cfg_prdata = {16'd0, scale_r};
      RegTol: cfg_prdata = {16'd0, tol_r};
      RegMaxIt: cfg_prdata = {18'd0, maxit_r};
      default: cfg_prdata = '0;
    endcase
  end
endmodule

>>> hdl/s2e_checker.sv
module s2e_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic converged,
  input logic [13:0] iterations_used
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("out dropped");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("busy accept");
  a_iter_conv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && converged |-> iterations_used != 0) else $error("conv no step");
endmodule

bind sphere_to_ellipse_projection s2e_checker u_chk (
  .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .converged(out_ch.converged), .iterations_used(out_ch.iterations_used));
